[rtl/core/ssd_pkg.sv]
package ssd_pkg;

   // default number of digits on the display
   localparam int NumDigits = 4;

   // fixed field widths
   localparam int DigitW     = 2;
   localparam int CharW      = 8;
   localparam int SegW       = 8;
   localparam int DigitPinsW = 4;
   localparam int MapW       = 64;
   localparam int CsrIndexW  = 2;

   // register indexes on the csr channel
   localparam logic [CsrIndexW-1:0] RegSegmentPinMap    = 2'd0;
   localparam logic [CsrIndexW-1:0] RegSegmentsActiveHi = 2'd1;
   localparam logic [CsrIndexW-1:0] RegDigitsActiveHi   = 2'd2;

   // register reset values
   localparam logic [MapW-1:0]       SegmentPinMapReset = 64'h8040_2010_0804_0201;
   localparam logic                  SegmentsActiveHiReset = 1'b1;
   localparam logic [DigitPinsW-1:0] DigitsActiveHiReset = 4'hF;

   // item kinds
   localparam logic KindSet  = 1'b0;
   localparam logic KindShow = 1'b1;

   // character codes
   localparam logic [6:0] CharLowerA = 7'h61;
   localparam logic [6:0] CharLowerZ = 7'h7A;
   localparam logic [6:0] Char0      = 7'h30;
   localparam logic [6:0] Char9      = 7'h39;
   localparam logic [6:0] CharUpperA = 7'h41;
   localparam logic [6:0] CharUpperR = 7'h52;
   localparam logic [6:0] CharDash   = 7'h2D;

   localparam logic [SegW-1:0] DashShape = 8'h40;
   localparam logic [SegW-1:0] DotShape  = 8'h80;

   localparam logic [SegW-1:0] NumeralShapes [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   // letters a..r, k m q blank
   localparam logic [SegW-1:0] LetterShapes [18] = '{
      8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h7D, 8'h76, 8'h30,
      8'h0E, 8'h00, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h00, 8'h50
   };

   // character code to segment shape (bit 0 = A .. bit 6 = G, bit 7 = DP)
   function automatic logic [SegW-1:0] glyph(input logic [CharW-1:0] code);
      logic [6:0]      c;
      logic [SegW-1:0] shape;
      c     = code[6:0];
      shape = '0;
      if (c >= CharLowerA && c <= CharLowerZ) begin
         c = c - (CharLowerA - CharUpperA);
      end
      if (c >= Char0 && c <= Char9) begin
         shape = NumeralShapes[4'(c - Char0)];
      end else if (c >= CharUpperA && c <= CharUpperR) begin
         shape = LetterShapes[5'(c - CharUpperA)];
      end else if (c == CharDash) begin
         shape = DashShape;
      end
      if (code[7]) begin
         shape = shape | DotShape;
      end
      return shape;
   endfunction

   // route a shape through the per-segment pin map
   function automatic logic [SegW-1:0] map_pins(input logic [SegW-1:0] shape,
                                                input logic [MapW-1:0] pin_map);
      logic [SegW-1:0] pins;
      pins = '0;
      for (int s = 0; s < SegW; s++) begin
         if (shape[s]) begin
            pins = pins | pin_map[8*s +: 8];
         end
      end
      return pins;
   endfunction

   // every pin driven by some segment
   function automatic logic [SegW-1:0] pin_mask(input logic [MapW-1:0] pin_map);
      logic [SegW-1:0] m;
      m = '0;
      for (int s = 0; s < SegW; s++) begin
         m = m | pin_map[8*s +: 8];
      end
      return m;
   endfunction

endpackage

[rtl/core/seven_segment_mux_display_core.sv]
// channel | direction | transaction carries
// --------+-----------+---------------------------------------------------
// req_    | in        | tuser: kind; tdata: digit, character
// rsp_    | out       | tdata: segment_pins, digit_pins
// csr_    | in        | register index and write data, always ready
//
// one item per clock while rsp_tready is high; two register stages: an input
// register and a result register, so an item's result is offered from the result
// register; the result register only stalls the input register when rsp_tready is low,
// the input register refills as soon as it hands its item on
// synchronous active-high reset clears stored patterns, shown digit and
// valids; registers go back to their power-on values
module seven_segment_mux_display_core #(
   parameter int NUM_DIGITS = ssd_pkg::NumDigits
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // digit[1:0], character[9:2], zero
   input  logic                          req_tuser,   // kind[0]
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,   // segment_pins[7:0], digit_pins[11:8], zero
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ssd_pkg::CsrIndexW-1:0] csr_index,
   input  logic [ssd_pkg::MapW-1:0]      csr_data
);

   // only digits reachable by the index field and the select pins are kept
   localparam int NumStored = (NUM_DIGITS < ssd_pkg::DigitPinsW) ? NUM_DIGITS
                                                                 : ssd_pkg::DigitPinsW;
   localparam int IdxW = (NumStored > 1) ? $clog2(NumStored) : 1;
   localparam logic [ssd_pkg::DigitPinsW-1:0] DigitLanes =
      ssd_pkg::DigitPinsW'((1 << NumStored) - 1);

   // configuration registers
   logic [ssd_pkg::MapW-1:0]       pin_map_ff;
   logic                           seg_active_hi_ff;
   logic [ssd_pkg::DigitPinsW-1:0] dig_active_hi_ff;

   // input register
   logic                        in_valid_ff;
   logic                        in_kind_ff;
   logic [ssd_pkg::DigitW-1:0]  in_digit_ff;
   logic [ssd_pkg::CharW-1:0]   in_char_ff;

   // display state
   logic [ssd_pkg::SegW-1:0]    patterns_ff [NumStored];
   logic [ssd_pkg::SegW-1:0]    shown_pattern_ff;
   logic [ssd_pkg::DigitW-1:0]  shown_digit_ff;
   logic                        active_ff;

   // result register
   logic                        out_valid_ff;
   logic [ssd_pkg::SegW-1:0]       out_seg_ff;
   logic [ssd_pkg::DigitPinsW-1:0] out_dig_ff;

   logic                           advance;
   logic                           in_range;
   logic [IdxW-1:0]                idx;
   logic [ssd_pkg::SegW-1:0]       new_pins;
   logic [ssd_pkg::SegW-1:0]       shown_pattern_in;
   logic [ssd_pkg::DigitW-1:0]     shown_digit_in;
   logic                           active_in;
   logic [ssd_pkg::SegW-1:0]       mask;
   logic [ssd_pkg::SegW-1:0]       out_seg_in;
   logic [ssd_pkg::DigitPinsW-1:0] out_dig_in;

   // item moves from the input register into the result register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign in_range = ({30'd0, in_digit_ff} < 32'(NUM_DIGITS));
   assign idx      = IdxW'(in_digit_ff);

   // new pin set for a set item, mapped at set time
   assign new_pins = ssd_pkg::map_pins(ssd_pkg::glyph(in_char_ff), pin_map_ff);

   always_comb begin
      shown_pattern_in = shown_pattern_ff;
      shown_digit_in   = shown_digit_ff;
      active_in        = active_ff;
      if (in_range && in_kind_ff == ssd_pkg::KindShow) begin
         shown_pattern_in = patterns_ff[idx];
         shown_digit_in   = in_digit_ff;
         active_in        = 1'b1;
      end
   end

   // port levels after the item: mask and polarity applied at output
   always_comb begin
      mask = ssd_pkg::pin_mask(pin_map_ff);
      if (seg_active_hi_ff) begin
         out_seg_in = shown_pattern_in & mask;
      end else begin
         out_seg_in = ~shown_pattern_in & mask;
      end
      out_dig_in = ~dig_active_hi_ff & DigitLanes;
      if (active_in) begin
         out_dig_in = out_dig_in ^
            ((ssd_pkg::DigitPinsW'(1) << shown_digit_in) & DigitLanes);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_map_ff       <= ssd_pkg::SegmentPinMapReset;
         seg_active_hi_ff <= ssd_pkg::SegmentsActiveHiReset;
         dig_active_hi_ff <= ssd_pkg::DigitsActiveHiReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ssd_pkg::RegSegmentPinMap:    pin_map_ff       <= csr_data;
            ssd_pkg::RegSegmentsActiveHi: seg_active_hi_ff <= csr_data[0];
            ssd_pkg::RegDigitsActiveHi:   dig_active_hi_ff <= csr_data[3:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_kind_ff  <= req_tuser;
         in_digit_ff <= req_tdata[1:0];
         in_char_ff  <= req_tdata[9:2];
      end
   end

   // display state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumStored; i++) begin
            patterns_ff[i] <= '0;
         end
         shown_pattern_ff <= '0;
         shown_digit_ff   <= '0;
         active_ff        <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (advance) begin
            if (in_range && in_kind_ff == ssd_pkg::KindSet) begin
               patterns_ff[idx] <= new_pins;
            end
            shown_pattern_ff <= shown_pattern_in;
            shown_digit_ff   <= shown_digit_in;
            active_ff        <= active_in;
            out_valid_ff     <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_seg_ff <= out_seg_in;
         out_dig_ff <= out_dig_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_dig_ff, out_seg_ff};

endmodule
